// ===== design/wbr_pkg.sv =====
// Shared types and constants for the Winnow block reconciler.
`timescale 1ns / 1ps
`default_nettype none
package wbr_pkg;

  localparam int BlockW  = 7;
  localparam int SynW    = 3;
  localparam int IndexW  = 16;
  localparam int CountW  = 3;

  // Hamming(7,4) check rows; bit k of the syndrome is the parity of row k.
  localparam logic [BlockW-1:0] CHECK_ROWS [SynW] = '{7'h55, 7'h33, 7'h0F};

  localparam logic [CountW-1:0] KEPT_FULL = 3'd7;
  localparam logic [CountW-1:0] KEPT_CORR = 3'd4;

  typedef enum logic {
    MODE_PARITY  = 1'b0,
    MODE_CORRECT = 1'b1
  } wbr_mode_t;

  typedef struct packed {
    logic [BlockW-1:0] block_bits;
    logic              peer_parity;
    logic              flagged;
    logic [SynW-1:0]   peer_syndrome;
  } wbr_in_t;

  typedef struct packed {
    logic [IndexW-1:0] block_index;
    logic              parity_mismatch;
    logic [SynW-1:0]   local_syndrome;
    logic [BlockW-1:0] kept_bits;
    logic [CountW-1:0] kept_count;
  } wbr_out_t;

endpackage
`default_nettype wire

// ===== design/wbr_datapath.sv =====
// Combinational parity, syndrome, correction and discard logic for one block.
`timescale 1ns / 1ps
`default_nettype none
module wbr_datapath (
  input  wire wbr_pkg::wbr_in_t             item,
  input  wire wbr_pkg::wbr_mode_t           mode,
  input  wire logic [wbr_pkg::IndexW-1:0]   block_index,
  output wbr_pkg::wbr_out_t                 result
);
  import wbr_pkg::*;

  logic [SynW-1:0]   syn;
  logic [SynW-1:0]   comb_syn;
  logic [BlockW-1:0] flip_mask;
  logic [BlockW-1:0] fixed;
  logic              parity;

  always_comb begin
    for (int k = 0; k < SynW; k++) begin
      syn[k] = ^(item.block_bits & CHECK_ROWS[k]);
    end
    parity   = ^item.block_bits;
    comb_syn = syn ^ item.peer_syndrome;
    // A nonzero combined syndrome s names position 7 - s; zero flips nothing.
    flip_mask = '0;
    if (comb_syn != '0) begin
      flip_mask[3'(BlockW) - comb_syn] = 1'b1;
    end
    fixed = item.block_bits ^ flip_mask;
  end

  always_comb begin
    result.block_index     = block_index;
    result.local_syndrome  = syn;
    result.parity_mismatch = 1'b0;
    result.kept_bits       = item.block_bits;
    result.kept_count      = KEPT_FULL;
    if (mode == MODE_PARITY) begin
      result.parity_mismatch = parity ^ item.peer_parity;
    end else if (item.flagged) begin
      // Positions 3, 5 and 6 are discarded; the rest pack from bit 0.
      result.kept_bits  = {3'b000, fixed[4], fixed[2], fixed[1], fixed[0]};
      result.kept_count = KEPT_CORR;
    end
  end

endmodule
`default_nettype wire

// ===== design/winnow_block_reconciler.sv =====
// Top level of the Winnow block reconciler: input register, block logic, result register.
// An accepted block is registered in stage one; its result is registered in the result
// register. Throughput: one block per cycle when the output is not stalled; the input
// register, the block logic and the result register form a two-stage pipeline that
// advances whenever its head is free.
// Reset (rst, synchronous): both pipeline stages empty, pass_mode set to parity
// mode, block counter cleared. Writing pass_mode also clears the block counter.
`timescale 1ns / 1ps
`default_nettype none
module winnow_block_reconciler #(
  parameter int INDEX_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  // Input blocks.
  input  wire                     item_valid,
  output logic                    item_stall,
  input  wire wbr_pkg::wbr_in_t   item,
  // Results.
  output logic                    result_valid,
  input  wire                     result_stall,
  output wbr_pkg::wbr_out_t       result,
  // Mode register write channel.
  input  wire                     mode_valid,
  output logic                    mode_ready,
  input  wire                     mode_data
);
  import wbr_pkg::*;

  // Running block number; it wraps at INDEX_BITS bits and is reported as its
  // low 16 bits (zero-extended when the counter is narrower).
  logic [INDEX_BITS-1:0] block_counter;
  wbr_mode_t             pass_mode;

  // Stage one: the accepted beat together with its block number and mode.
  logic                  s1_valid;
  wbr_in_t               s1_item;
  logic [IndexW-1:0]     s1_index;
  wbr_mode_t             s1_mode;

  wbr_out_t              result_next;

  logic                  adv_out;
  logic                  adv_s1;
  logic                  item_take;
  logic                  mode_write;

  // The result register may load whenever it is empty or its beat leaves now;
  // stage one may load whenever it is empty or moves forward. The stall path is
  // thus a short chain of gates from result_stall, and no bubble is needed.
  assign adv_out    = !result_valid || !result_stall;
  assign adv_s1     = !s1_valid || adv_out;
  assign item_stall = !adv_s1;
  assign item_take  = item_valid && adv_s1;

  // The mode register is always writable; writes are expected only while idle.
  assign mode_ready = 1'b1;
  assign mode_write = mode_valid && mode_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      pass_mode     <= MODE_PARITY;
    end else if (mode_write) begin
      block_counter <= '0;
      pass_mode     <= wbr_mode_t'(mode_data);
    end else if (item_take) begin
      block_counter <= block_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_s1) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_item  <= item;
      s1_index <= IndexW'(block_counter);
      s1_mode  <= pass_mode;
    end
  end

  wbr_datapath u_datapath (
    .item        (s1_item),
    .mode        (s1_mode),
    .block_index (s1_index),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_out) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      result <= result_next;
    end
  end

  // The counter advances by exactly one for each accepted beat that does not coincide with a mode write.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (item_take && !mode_write) |=>
      block_counter == INDEX_BITS'($past(block_counter) + 1'b1))
    else $error("block counter did not advance by one on an accepted beat");

  // A mode write restarts the block numbering.
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    mode_write |=> block_counter == '0)
    else $error("block counter not cleared by a mode write");

  // A parity mismatch only arises in parity mode, where nothing is discarded.
  a_mismatch_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.parity_mismatch) |-> result.kept_count == KEPT_FULL)
    else $error("parity mismatch reported on a shortened block");

  // A full pipeline behind a stalled output holds its input side stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result_valid && result_stall) |-> item_stall)
    else $error("input accepted while the pipeline is full and stalled");

endmodule
`default_nettype wire
